// ===== src/ypvr_pkg.sv =====
// ----------------------------------------------------------------------------
// ypvr_pkg
// shared widths, types, sine table and angle helpers for the yaw/pitch rotator
// ----------------------------------------------------------------------------
package ypvr_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int TRIG_FRAC_BITS  = 14;
    localparam int TABLE_FRAC_BITS = 14;
    localparam int TRIG_W          = TRIG_FRAC_BITS + 2;
    localparam int PROD_W          = COORD_WIDTH + TRIG_W;
    localparam int ACC_W           = PROD_W + 2;
    localparam int ANGLE_W         = 9;
    localparam int IDX_W           = 7;
    localparam int TABLE_DEPTH     = 91;

    localparam int TRIG_UP  = (TRIG_FRAC_BITS >= TABLE_FRAC_BITS) ?
                              (TRIG_FRAC_BITS - TABLE_FRAC_BITS) : 0;
    localparam int TRIG_DN  = (TRIG_FRAC_BITS >= TABLE_FRAC_BITS) ?
                              0 : (TABLE_FRAC_BITS - TRIG_FRAC_BITS);
    localparam int TRIG_RND = (1 << TRIG_DN) >> 1;

    localparam logic [ANGLE_W-1:0] DEG_QUARTER       = ANGLE_W'(90);
    localparam logic [ANGLE_W-1:0] DEG_HALF_TURN     = ANGLE_W'(180);
    localparam logic [ANGLE_W-1:0] DEG_THREE_QUARTER = ANGLE_W'(270);
    localparam logic [ANGLE_W-1:0] DEG_FULL_TURN     = ANGLE_W'(360);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]      trig_val_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    localparam trig_val_t TRIG_ONE   = TRIG_W'(2 ** TRIG_FRAC_BITS);
    localparam acc_t      ROUND_HALF = ACC_W'(2 ** (TRIG_FRAC_BITS - 1));
    localparam acc_t      SAT_HI     = {{(ACC_W - COORD_WIDTH + 1){1'b0}},
                                        {(COORD_WIDTH - 1){1'b1}}};
    localparam acc_t      SAT_LO     = ~SAT_HI;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
    } trig_sel_t;

    typedef struct packed {
        trig_sel_t sy;
        trig_sel_t cy;
        trig_sel_t sp;
        trig_sel_t cp;
    } trig_sel_set_t;

    typedef struct packed {
        trig_val_t sy;
        trig_val_t cy;
        trig_val_t sp;
        trig_val_t cp;
    } trig_set_t;

    localparam logic [14:0] SINE_Q14 [TABLE_DEPTH] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // one subtraction brings any 9-bit angle into 0..359
    function automatic logic [ANGLE_W-1:0] reduce_angle(input logic [ANGLE_W-1:0] raw);
        return (raw >= DEG_FULL_TURN) ? (raw - DEG_FULL_TURN) : raw;
    endfunction

    function automatic logic [ANGLE_W-1:0] quarter_ahead(input logic [ANGLE_W-1:0] d);
        logic [ANGLE_W:0] s;
        s = {1'b0, d} + {1'b0, DEG_QUARTER};
        if (s >= {1'b0, DEG_FULL_TURN})
        begin
            s = s - {1'b0, DEG_FULL_TURN};
        end
        return s[ANGLE_W-1:0];
    endfunction

    // quadrant fold onto the quarter-wave table
    function automatic trig_sel_t sine_sel(input logic [ANGLE_W-1:0] d);
        trig_sel_t        sel;
        logic [ANGLE_W-1:0] a;
        sel.neg = 1'b0;
        if (d <= DEG_QUARTER)
        begin
            a = d;
        end
        else if (d <= DEG_HALF_TURN)
        begin
            a = DEG_HALF_TURN - d;
        end
        else if (d <= DEG_THREE_QUARTER)
        begin
            a = d - DEG_HALF_TURN;
            sel.neg = 1'b1;
        end
        else
        begin
            a = DEG_FULL_TURN - d;
            sel.neg = 1'b1;
        end
        if (a > DEG_QUARTER)
        begin
            a = DEG_QUARTER;
        end
        sel.idx = a[IDX_W-1:0];
        return sel;
    endfunction

    function automatic logic [TRIG_FRAC_BITS:0] sine_mag(input logic [IDX_W-1:0] idx);
        int m;
        int i;
        i = (int'(idx) > TABLE_DEPTH - 1) ? (TABLE_DEPTH - 1) : int'(idx);
        m = int'(SINE_Q14[i]);
        return (TRIG_FRAC_BITS + 1)'(((m << TRIG_UP) + TRIG_RND) >> TRIG_DN);
    endfunction

    function automatic trig_val_t trig_value(input trig_sel_t sel);
        trig_val_t mag;
        mag = trig_val_t'({1'b0, sine_mag(sel.idx)});
        return sel.neg ? -mag : mag;
    endfunction

endpackage

// ===== src/ypvr_trig.sv =====
// ----------------------------------------------------------------------------
// ypvr_trig
// two-stage sine/cosine lookup: angle fold, then table read and sign
// ----------------------------------------------------------------------------
module ypvr_trig
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ypvr_pkg::ANGLE_W-1:0]  yaw_deg,
    input  logic [ypvr_pkg::ANGLE_W-1:0]  pitch_deg,
    output logic                          out_valid,
    output ypvr_pkg::trig_set_t           trig
);
    import ypvr_pkg::*;

    logic            sel_valid_reg;
    trig_sel_set_t   sel_reg;
    trig_sel_set_t   sel_next;
    logic            trig_valid_reg;
    trig_set_t       trig_reg;
    trig_set_t       trig_next;
    logic [ANGLE_W-1:0] yaw_red;
    logic [ANGLE_W-1:0] pitch_red;

    always_comb
    begin
        yaw_red     = reduce_angle(yaw_deg);
        pitch_red   = reduce_angle(pitch_deg);
        sel_next.sy = sine_sel(yaw_red);
        sel_next.cy = sine_sel(quarter_ahead(yaw_red));
        sel_next.sp = sine_sel(pitch_red);
        sel_next.cp = sine_sel(quarter_ahead(pitch_red));
    end

    always_comb
    begin
        trig_next.sy = trig_value(sel_reg.sy);
        trig_next.cy = trig_value(sel_reg.cy);
        trig_next.sp = trig_value(sel_reg.sp);
        trig_next.cp = trig_value(sel_reg.cp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg  <= 1'b0;
            trig_valid_reg <= 1'b0;
        end
        else
        begin
            sel_valid_reg  <= in_valid;
            trig_valid_reg <= sel_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        trig_reg <= trig_next;
    end

    assign out_valid = trig_valid_reg;
    assign trig      = trig_reg;

    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##2 out_valid)
        else $error("trig valid lost in pipeline");

    a_yaw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && (yaw_deg == 9'd0 || yaw_deg == DEG_FULL_TURN))
        |-> ##2 (trig.sy == '0 && trig.cy == TRIG_ONE))
        else $error("yaw of zero gives wrong sine/cosine");

    a_pitch_quarter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && pitch_deg == DEG_QUARTER)
        |-> ##2 (trig.sp == TRIG_ONE && trig.cp == '0))
        else $error("pitch of a quarter turn gives wrong sine/cosine");

endmodule

// ===== src/ypvr_rot.sv =====
// ----------------------------------------------------------------------------
// ypvr_rot
// plane rotation: four products, then sum, round and saturate
// out0 = u*c - v*s, out1 = u*s + v*c
// ----------------------------------------------------------------------------
module ypvr_rot
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ypvr_pkg::coord_t    u,
    input  ypvr_pkg::coord_t    v,
    input  ypvr_pkg::trig_val_t s,
    input  ypvr_pkg::trig_val_t c,
    output logic                out_valid,
    output ypvr_pkg::coord_t    out0,
    output ypvr_pkg::coord_t    out1
);
    import ypvr_pkg::*;

    logic   prod_valid_reg;
    prod_t  uc_reg;
    prod_t  us_reg;
    prod_t  vc_reg;
    prod_t  vs_reg;
    logic   res_valid_reg;
    coord_t out0_reg;
    coord_t out1_reg;
    coord_t out0_next;
    coord_t out1_next;
    acc_t   acc0;
    acc_t   acc1;

    function automatic coord_t round_sat(input acc_t acc);
        acc_t q;
        q = (acc + ROUND_HALF) >>> TRIG_FRAC_BITS;
        if (q > SAT_HI)
        begin
            q = SAT_HI;
        end
        else if (q < SAT_LO)
        begin
            q = SAT_LO;
        end
        return q[COORD_WIDTH-1:0];
    endfunction

    always_comb
    begin
        acc0      = ACC_W'(uc_reg) - ACC_W'(vs_reg);
        acc1      = ACC_W'(us_reg) + ACC_W'(vc_reg);
        out0_next = round_sat(acc0);
        out1_next = round_sat(acc1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            res_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        uc_reg   <= prod_t'(u) * prod_t'(c);
        us_reg   <= prod_t'(u) * prod_t'(s);
        vc_reg   <= prod_t'(v) * prod_t'(c);
        vs_reg   <= prod_t'(v) * prod_t'(s);
        out0_reg <= out0_next;
        out1_reg <= out1_next;
    end

    assign out_valid = res_valid_reg;
    assign out0      = out0_reg;
    assign out1      = out1_reg;

    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##2 out_valid)
        else $error("rotation valid lost in pipeline");

    a_valid_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, 2))
        else $error("rotation result without a transfer behind it");

    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && u == '0 && v == '0) |-> ##2 (out0 == '0 && out1 == '0))
        else $error("zero vector does not rotate to zero");

endmodule

// ===== src/yaw_pitch_vector_rotator.sv =====
// ----------------------------------------------------------------------------
// yaw_pitch_vector_rotator
// rotates a Q15.8 vector about y by yaw, then about x by pitch, saturating
// ----------------------------------------------------------------------------
// A vector transfer is taken on every cycle with start high; busy never rises.
// Each result appears on rot_x/rot_y/rot_z with done high for one cycle,
// after it has passed, in order, the sine/cosine lookup (angle fold, then
// table read and sign), the yaw rotation (multiply, then round and saturate)
// and the pitch rotation (multiply, then round and saturate). The receiver
// cannot stall, so results must be captured when done is high.
// ----------------------------------------------------------------------------
module yaw_pitch_vector_rotator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ypvr_pkg::coord_t              vec_x,
    input  ypvr_pkg::coord_t              vec_y,
    input  ypvr_pkg::coord_t              vec_z,
    input  logic [ypvr_pkg::ANGLE_W-1:0]  yaw_deg,
    input  logic [ypvr_pkg::ANGLE_W-1:0]  pitch_deg,
    output logic                          done,
    output ypvr_pkg::coord_t              rot_x,
    output ypvr_pkg::coord_t              rot_y,
    output ypvr_pkg::coord_t              rot_z
);
    import ypvr_pkg::*;

    logic      trig_valid;
    trig_set_t trig;
    logic      yaw_valid;
    coord_t    z1;
    coord_t    x1;
    logic      pitch_valid;
    coord_t    ry;
    coord_t    rz;

    coord_t    x_s1_reg;
    coord_t    x_s2_reg;
    coord_t    y_s1_reg;
    coord_t    y_s2_reg;
    coord_t    y_s3_reg;
    coord_t    y_s4_reg;
    coord_t    z_s1_reg;
    coord_t    z_s2_reg;
    trig_val_t sp_s3_reg;
    trig_val_t sp_s4_reg;
    trig_val_t cp_s3_reg;
    trig_val_t cp_s4_reg;
    coord_t    x1_s5_reg;
    coord_t    x1_s6_reg;

    assign busy = 1'b0;

    ypvr_trig u_trig
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .yaw_deg   (yaw_deg),
        .pitch_deg (pitch_deg),
        .out_valid (trig_valid),
        .trig      (trig)
    );

    // yaw: z1 = z*cy - x*sy, x1 = z*sy + x*cy
    ypvr_rot u_yaw
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .u         (z_s2_reg),
        .v         (x_s2_reg),
        .s         (trig.sy),
        .c         (trig.cy),
        .out_valid (yaw_valid),
        .out0      (z1),
        .out1      (x1)
    );

    // pitch: ry = y*cp - z1*sp, rz = y*sp + z1*cp
    ypvr_rot u_pitch
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (yaw_valid),
        .u         (y_s4_reg),
        .v         (z1),
        .s         (sp_s4_reg),
        .c         (cp_s4_reg),
        .out_valid (pitch_valid),
        .out0      (ry),
        .out1      (rz)
    );

    // side data delayed to line up with the rotation stages
    always_ff @(posedge clk)
    begin
        x_s1_reg  <= vec_x;
        x_s2_reg  <= x_s1_reg;
        y_s1_reg  <= vec_y;
        y_s2_reg  <= y_s1_reg;
        y_s3_reg  <= y_s2_reg;
        y_s4_reg  <= y_s3_reg;
        z_s1_reg  <= vec_z;
        z_s2_reg  <= z_s1_reg;
        sp_s3_reg <= trig.sp;
        sp_s4_reg <= sp_s3_reg;
        cp_s3_reg <= trig.cp;
        cp_s4_reg <= cp_s3_reg;
        x1_s5_reg <= x1;
        x1_s6_reg <= x1_s5_reg;
    end

    assign done  = pitch_valid;
    assign rot_x = x1_s6_reg;
    assign rot_y = ry;
    assign rot_z = rz;

endmodule
